// ===== rtl/lgts_pkg.sv =====
// Shared constants, types and helpers for the topic sampler.
package lgts_pkg;

    localparam int TOPICS_DEF = 64;
    localparam int WORDS_DEF  = 1024;
    localparam int DOCS_DEF   = 256;

    localparam logic [2:0] OP_WR_WEIGHT = 3'd0;
    localparam logic [2:0] OP_WR_PRIOR  = 3'd1;
    localparam logic [2:0] OP_ADD       = 3'd2;
    localparam logic [2:0] OP_RESAMPLE  = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    localparam logic CFG_BETA  = 1'b0;
    localparam logic CFG_VOCAB = 1'b1;

    localparam logic [31:0] BETA_RST  = 32'd6554;
    localparam logic [10:0] VOCAB_RST = 11'd1024;

    localparam logic [63:0] SCORE_MAX = 64'h00FF_FFFF_FFFF_FFFF;

    localparam int QW  = 49;
    localparam int VBW = 43;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_sub32(logic [31:0] a, logic [15:0] b);
        return ({16'b0, b} > a) ? 32'd0 : a - {16'b0, b};
    endfunction

endpackage

// ===== rtl/lgts_mul.sv =====
// Shared 16 by 64 bit multiply-accumulate unit, one digit of the multiplier per cycle.
module lgts_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [63:0]          i_x,
    input  logic [63:0]          i_y,
    input  logic [1:0]           i_last_dig,
    output logic [127:0]         o_prod,
    output lgts_pkg::t_unit_sts  o_sts
);
    import lgts_pkg::*;

    logic [127:0] r_acc;
    logic [63:0]  r_x;
    logic [63:0]  r_y;
    logic [1:0]   r_dig;
    logic [1:0]   r_last;
    logic         r_busy;
    logic         r_done;
    logic [79:0]  w_part;
    logic [127:0] w_term;

    assign w_part = 80'(r_x) * 80'(r_y[15:0]);
    assign w_term = 128'(w_part) << {r_dig, 4'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_dig == r_last);
            if (i_start) begin
                r_acc  <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_dig  <= 2'd0;
                r_last <= i_last_dig;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + w_term;
                r_y   <= r_y >> 16;
                if (r_dig == r_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_dig <= r_dig + 2'd1;
                end
            end
        end
    end

    assign o_prod = r_acc;
    assign o_sts  = '{busy: r_busy, done: r_done};

endmodule

// ===== rtl/lgts_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating when the quotient overflows.
module lgts_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [63:0]          i_hi,
    input  logic [63:0]          i_lo,
    input  logic [lgts_pkg::QW-1:0] i_den,
    output logic [63:0]          o_quo,
    output lgts_pkg::t_unit_sts  o_sts
);
    import lgts_pkg::*;

    logic [QW:0]   r_rem;
    logic [63:0]   r_lo;
    logic [63:0]   r_q;
    logic [QW-1:0] r_den;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [QW+1:0] w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_lo[63]};
    assign w_ge    = w_trial >= {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_start ? (i_hi >= 64'(i_den)) : (r_busy && r_cnt == 6'd63);
            if (i_start) begin
                if (i_hi >= 64'(i_den)) begin
                    r_q    <= '1;
                end else begin
                    r_rem  <= (QW+1)'(i_hi);
                    r_lo   <= i_lo;
                    r_den  <= i_den;
                    r_cnt  <= 6'd0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? (QW+1)'(w_trial - {2'b0, r_den}) : w_trial[QW:0];
                r_lo  <= r_lo << 1;
                r_q   <= {r_q[62:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quo = r_q;
    assign o_sts = '{busy: r_busy, done: r_done};

endmodule

// ===== rtl/lda_gibbs_token_sampler.sv =====
// Top level of the weighted collapsed Gibbs token sampler: sequencer, count tables, unit control.
// Writes, add and read: the item passes S_RD and S_OLD, then S_OUT registers the result once
// the output is free; one item at a time. Resample: per topic a 4-step multiply and a 64-step
// divide in the shared units, then a multiply by the uniform and a scan of the running sums.
// After reset a clearing pass over max(TOPICS*WORDS, TOPICS*DOCS) addresses zeroes the count
// tables; no item is taken meanwhile, configuration writes are.
module lda_gibbs_token_sampler #(
    parameter int TOPICS = lgts_pkg::TOPICS_DEF,
    parameter int WORDS  = lgts_pkg::WORDS_DEF,
    parameter int DOCS   = lgts_pkg::DOCS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // topic[5:0], word_index[15:6], doc_index[23:16], value[55:24], uniform[71:56]
    input  logic [71:0] i_s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // new_topic[5:0], read_count[37:6], underflow[38], zero[39]
    output logic [39:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import lgts_pkg::*;

    localparam int KW        = $clog2(TOPICS);
    localparam int WT_DEPTH  = TOPICS * WORDS;
    localparam int DT_DEPTH  = TOPICS * DOCS;
    localparam int WT_AW     = $clog2(WT_DEPTH);
    localparam int DT_AW     = $clog2(DT_DEPTH);
    localparam int CLR_DEPTH = (WT_DEPTH > DT_DEPTH) ? WT_DEPTH : DT_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_OLD, S_LRD, S_LDAT, S_MUL, S_DIV,
        S_TGT, S_SRD, S_SCMP, S_ARD, S_ADD, S_OUT
    } t_state;

    t_state r_state;

    logic [CLR_AW-1:0] r_clr;
    logic [31:0]       r_beta;
    logic [10:0]       r_vocab;
    logic [VBW-1:0]    r_vb;

    logic [2:0]        r_op;
    logic              r_ok;
    logic [5:0]        r_t;
    logic [9:0]        r_w;
    logic [7:0]        r_d;
    logic [31:0]       r_val;
    logic [15:0]       r_u;
    logic [KW-1:0]     r_k;
    logic [QW-1:0]     r_c;
    logic [63:0]       r_z;
    logic [63:0]       r_tgt;
    logic              r_flag;
    logic [31:0]       r_cnt_out;
    logic [5:0]        r_res_topic;
    logic              r_out_valid;
    logic [39:0]       r_out_data;

    logic [31:0] wt_mem  [WT_DEPTH];
    logic [15:0] wgt_mem [WT_DEPTH];
    logic [31:0] dt_mem  [DT_DEPTH];
    logic [31:0] pri_mem [DT_DEPTH];
    logic [31:0] tot_mem [TOPICS];
    logic [63:0] rs_mem  [TOPICS];

    logic [31:0] r_wt_q, r_dt_q, r_pri_q, r_tot_q;
    logic [15:0] r_wgt_q;
    logic [63:0] r_rs_q;

    logic [WT_AW-1:0] w_wt_addr;
    logic [DT_AW-1:0] w_dt_addr;
    logic [KW-1:0]    w_tot_addr;
    logic             w_wt_we, w_dt_we, w_tot_we, w_wgt_we, w_pri_we, w_rs_we;
    logic [31:0]      w_wt_wd, w_dt_wd, w_tot_wd;
    logic             w_add_mode;

    logic [QW-1:0]    w_a, w_b, w_c_raw, w_c;
    logic [63:0]      w_score, n_z;

    logic             w_mul_start;
    logic [63:0]      w_mul_x, w_mul_y;
    logic [1:0]       w_mul_last;
    logic [127:0]     w_prod;
    t_unit_sts        w_mul_sts;
    logic             w_div_start;
    logic [63:0]      w_quo;
    t_unit_sts        w_div_sts;

    logic             w_in_acc;
    logic             w_ok_in;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ok_in         = (32'(i_s_axis_tdata[5:0]) < TOPICS) &&
                             (32'(i_s_axis_tdata[15:6]) < WORDS) &&
                             (32'(i_s_axis_tdata[23:16]) < DOCS);

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_wt_addr  = WT_AW'(r_clr);
            w_dt_addr  = DT_AW'(r_clr);
            w_tot_addr = KW'(r_clr);
        end else begin
            w_wt_addr  = WT_AW'(r_k) * WT_AW'(WORDS) + WT_AW'(r_w);
            w_dt_addr  = DT_AW'(r_k) * DT_AW'(DOCS) + DT_AW'(r_d);
            w_tot_addr = r_k;
        end
    end

    assign w_add_mode = (r_state == S_ADD) || (r_op == OP_ADD);

    always_comb begin
        w_wt_we  = 1'b0;
        w_dt_we  = 1'b0;
        w_tot_we = 1'b0;
        w_wgt_we = 1'b0;
        w_pri_we = 1'b0;
        w_rs_we  = 1'b0;
        w_wt_wd  = w_add_mode ? sat_add32(r_wt_q, r_wgt_q)  : sat_sub32(r_wt_q, r_wgt_q);
        w_dt_wd  = w_add_mode ? sat_add32(r_dt_q, r_wgt_q)  : sat_sub32(r_dt_q, r_wgt_q);
        w_tot_wd = w_add_mode ? sat_add32(r_tot_q, r_wgt_q) : sat_sub32(r_tot_q, r_wgt_q);
        case (r_state)
            S_CLEAR: begin
                w_wt_we  = 32'(r_clr) < WT_DEPTH;
                w_dt_we  = 32'(r_clr) < DT_DEPTH;
                w_tot_we = 32'(r_clr) < TOPICS;
                w_wt_wd  = '0;
                w_dt_wd  = '0;
                w_tot_wd = '0;
            end
            S_OLD: begin
                if (r_ok) begin
                    w_wgt_we = (r_op == OP_WR_WEIGHT);
                    w_pri_we = (r_op == OP_WR_PRIOR);
                    w_wt_we  = (r_op == OP_ADD) || (r_op == OP_RESAMPLE);
                    w_dt_we  = w_wt_we;
                    w_tot_we = w_wt_we;
                end
            end
            S_ADD: begin
                w_wt_we  = 1'b1;
                w_dt_we  = 1'b1;
                w_tot_we = 1'b1;
            end
            S_DIV:   w_rs_we = w_div_sts.done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wt_we) wt_mem[w_wt_addr] <= w_wt_wd;
        r_wt_q <= wt_mem[w_wt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wgt_we) wgt_mem[w_wt_addr] <= r_val[15:0];
        r_wgt_q <= wgt_mem[w_wt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_dt_we) dt_mem[w_dt_addr] <= w_dt_wd;
        r_dt_q <= dt_mem[w_dt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_pri_we) pri_mem[w_dt_addr] <= r_val;
        r_pri_q <= pri_mem[w_dt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_tot_we) tot_mem[w_tot_addr] <= w_tot_wd;
        r_tot_q <= tot_mem[w_tot_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rs_we) rs_mem[r_k] <= n_z;
        r_rs_q <= rs_mem[r_k];
    end

    assign w_a     = QW'({r_dt_q, 16'b0}) + QW'(r_pri_q);
    assign w_b     = QW'({r_wt_q, 16'b0}) + QW'(r_beta);
    assign w_c_raw = QW'({r_tot_q, 16'b0}) + QW'(r_vb);
    assign w_c     = (w_c_raw == '0) ? QW'(1) : w_c_raw;
    assign w_score = (w_quo > SCORE_MAX) ? SCORE_MAX : w_quo;
    assign n_z     = r_z + w_score;

    always_comb begin
        w_mul_start = 1'b0;
        w_mul_x     = 64'(w_b);
        w_mul_y     = 64'(w_a);
        w_mul_last  = 2'd3;
        if (r_state == S_LDAT) begin
            w_mul_start = 1'b1;
        end else if (r_state == S_DIV && w_div_sts.done && r_k == KW'(TOPICS - 1)) begin
            w_mul_start = 1'b1;
            w_mul_x     = n_z;
            w_mul_y     = 64'(r_u);
            w_mul_last  = 2'd0;
        end
    end

    assign w_div_start = (r_state == S_MUL) && w_mul_sts.done;

    lgts_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mul_start),
        .i_x        (w_mul_x),
        .i_y        (w_mul_y),
        .i_last_dig (w_mul_last),
        .o_prod     (w_prod),
        .o_sts      (w_mul_sts)
    );

    lgts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_hi    (w_prod[127:64]),
        .i_lo    (w_prod[63:0]),
        .i_den   (r_c),
        .o_quo   (w_quo),
        .o_sts   (w_div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_beta      <= BETA_RST;
            r_vocab     <= VOCAB_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_vb <= VBW'(r_vocab) * VBW'(r_beta);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BETA:  r_beta  <= i_cfg_data;
                    CFG_VOCAB: r_vocab <= i_cfg_data[10:0];
                    default:   ;
                endcase
            end
            if (r_out_valid && i_m_axis_tready && r_state != S_OUT) r_out_valid <= 1'b0;

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLR_AW'(1);
                    if (r_clr == CLR_AW'(CLR_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op        <= i_s_axis_tuser;
                        r_ok        <= w_ok_in;
                        r_t         <= i_s_axis_tdata[5:0];
                        r_k         <= KW'(i_s_axis_tdata[5:0]);
                        r_w         <= i_s_axis_tdata[15:6];
                        r_d         <= i_s_axis_tdata[23:16];
                        r_val       <= i_s_axis_tdata[55:24];
                        r_u         <= i_s_axis_tdata[71:56];
                        r_flag      <= 1'b0;
                        r_cnt_out   <= '0;
                        r_state     <= S_RD;
                    end
                end
                S_RD: r_state <= S_OLD;
                S_OLD: begin
                    r_res_topic <= r_t;
                    if (r_ok && r_op == OP_RESAMPLE) begin
                        r_flag  <= ({16'b0, r_wgt_q} > r_wt_q) ||
                                   ({16'b0, r_wgt_q} > r_dt_q) ||
                                   ({16'b0, r_wgt_q} > r_tot_q);
                        r_z     <= '0;
                        r_k     <= '0;
                        r_state <= S_LRD;
                    end else begin
                        if (r_ok && r_op == OP_READ) r_cnt_out <= r_dt_q;
                        r_state <= S_OUT;
                    end
                end
                S_LRD: r_state <= S_LDAT;
                S_LDAT: begin
                    r_c     <= w_c;
                    r_state <= S_MUL;
                end
                S_MUL: if (w_mul_sts.done) r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_sts.done) begin
                        r_z <= n_z;
                        if (r_k == KW'(TOPICS - 1)) begin
                            r_state <= S_TGT;
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_LRD;
                        end
                    end
                end
                S_TGT: begin
                    if (w_mul_sts.done) begin
                        r_tgt   <= w_prod[79:16];
                        r_k     <= '0;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    if (r_rs_q >= r_tgt || r_k == KW'(TOPICS - 1)) begin
                        r_state <= S_ARD;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_ARD: r_state <= S_ADD;
                S_ADD: begin
                    r_res_topic <= 6'(r_k);
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {1'b0, r_flag, r_cnt_out, r_res_topic};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/lgts_checker.sv =====
// Port-level checks for the topic sampler and their binding to the top level.
module lgts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [71:0] i_s_axis_tdata,
    input logic [2:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [0:0]  i_cfg_index,
    input logic [31:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result item dropped or changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again while an item is in work");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("block ready or emitting straight after reset");

    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[38] |-> o_m_axis_tdata[37:6] == 32'd0)
        else $error("underflow and read count both set");

endmodule

bind lda_gibbs_token_sampler lgts_checker u_lgts_checker (.*);
